[hdl/spc_pkg.sv]
// spc_pkg: shared constants, types and helpers for the super prime checker
// no dependencies

package spc_pkg;

	localparam int VALUE_WIDTH = 31;
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	typedef logic [VALUE_WIDTH-1:0] val_t;

	localparam val_t RADIX = val_t'(10);
	localparam val_t DIV_THREE = val_t'(3);
	localparam val_t FIRST_DIV = val_t'(5);
	localparam val_t PAIR_OFS = val_t'(2);
	localparam val_t DIV_STEP = val_t'(6);
	localparam val_t ONE_VAL = val_t'(1);

	localparam logic [3:0] DIG_TWO = 4'd2;
	localparam logic [3:0] DIG_THREE = 4'd3;
	localparam logic [3:0] DIG_FIVE = 4'd5;
	localparam logic [3:0] DIG_SEVEN = 4'd7;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIGIT,
		S_DIG_WAIT,
		S_PCHK,
		S_MOD3,
		S_TRY,
		S_WAIT_LO,
		S_WAIT_HI,
		S_OUT
	} seq_state_t;

	typedef struct packed {
		logic go;
		val_t dividend;
		val_t divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		val_t quotient;
		val_t remainder;
	} div_rsp_t;

	function automatic logic is_prime_digit(input logic [3:0] dig);
		return (dig == DIG_TWO) || (dig == DIG_THREE) || (dig == DIG_FIVE) ||
			(dig == DIG_SEVEN);
	endfunction

endpackage

[hdl/spc_div.sv]
// spc_div: shared restoring divider, one quotient bit per cycle
// depends on spc_pkg

module spc_div
	import spc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	val_t             rem_q;
	val_t             quo_q;
	val_t             dsr_q;

	logic [VALUE_WIDTH:0] shifted;
	logic [VALUE_WIDTH:0] diff;
	logic                 ge;

	assign shifted = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign diff = shifted - {1'b0, dsr_q};
	assign ge = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.go) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(VALUE_WIDTH);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
			quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
		end else if (req.go) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.remainder = rem_q;

endmodule

[hdl/spc_seq.sv]
// spc_seq: sequencer for digit check and 6k+-1 trial division
// depends on spc_pkg, drives spc_div through a request struct

module spc_seq
	import spc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  val_t     value,
	input  div_rsp_t rsp,
	output div_req_t req,
	output logic     busy,
	output logic     done,
	output logic     is_prime,
	output logic     digits_all_prime
);

	seq_state_t state_q, state_d;
	val_t       n_q, n_d;
	val_t       num_q, num_d;
	val_t       dv_q, dv_d;
	logic       dig_ok_q, dig_ok_d;
	logic       prime_q, prime_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q <= n_d;
		num_q <= num_d;
		dv_q <= dv_d;
		dig_ok_q <= dig_ok_d;
		prime_q <= prime_d;
	end

	always_comb begin
		state_d = state_q;
		n_d = n_q;
		num_d = num_q;
		dv_d = dv_q;
		dig_ok_d = dig_ok_q;
		prime_d = prime_q;
		req.go = 1'b0;
		req.dividend = n_q;
		req.divisor = dv_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					n_d = value;
					num_d = value;
					dig_ok_d = 1'b1;
					state_d = S_DIGIT;
				end
			end
			S_DIGIT: begin
				if (num_q == '0) begin
					state_d = S_PCHK;
				end else begin
					req.go = 1'b1;
					req.dividend = num_q;
					req.divisor = RADIX;
					state_d = S_DIG_WAIT;
				end
			end
			S_DIG_WAIT: begin
				if (rsp.done) begin
					if (!is_prime_digit(rsp.remainder[3:0])) begin
						dig_ok_d = 1'b0;
						state_d = S_PCHK;
					end else begin
						num_d = rsp.quotient;
						state_d = S_DIGIT;
					end
				end
			end
			S_PCHK: begin
				if (n_q <= ONE_VAL) begin
					prime_d = 1'b0;
					state_d = S_OUT;
				end else if (n_q <= DIV_THREE) begin
					prime_d = 1'b1;
					state_d = S_OUT;
				end else if (!n_q[0]) begin
					prime_d = 1'b0;
					state_d = S_OUT;
				end else begin
					req.go = 1'b1;
					req.divisor = DIV_THREE;
					state_d = S_MOD3;
				end
			end
			S_MOD3: begin
				if (rsp.done) begin
					if (rsp.remainder == '0) begin
						prime_d = 1'b0;
						state_d = S_OUT;
					end else begin
						dv_d = FIRST_DIV;
						state_d = S_TRY;
					end
				end
			end
			S_TRY: begin
				req.go = 1'b1;
				state_d = S_WAIT_LO;
			end
			S_WAIT_LO: begin
				if (rsp.done) begin
					if (dv_q > rsp.quotient) begin
						prime_d = 1'b1;
						state_d = S_OUT;
					end else if (rsp.remainder == '0) begin
						prime_d = 1'b0;
						state_d = S_OUT;
					end else begin
						req.go = 1'b1;
						req.divisor = dv_q + PAIR_OFS;
						state_d = S_WAIT_HI;
					end
				end
			end
			S_WAIT_HI: begin
				if (rsp.done) begin
					if (rsp.remainder == '0) begin
						prime_d = 1'b0;
						state_d = S_OUT;
					end else begin
						dv_d = dv_q + DIV_STEP;
						state_d = S_TRY;
					end
				end
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT;
	assign is_prime = prime_q;
	assign digits_all_prime = dig_ok_q;

endmodule

[hdl/super_prime_checker_unit.sv]
// super_prime_checker_unit: top level, sequencer plus shared divider
// depends on spc_pkg, spc_seq, spc_div
// work per word: one word needs up to one division on the shared divider per decimal digit,
// one for the test by 3 and two per 6k+-1 divisor pair; even and small values end after
// the digit check, with no trial division
// one word at a time: busy stays high until the done strobe; the receiver cannot stall
// reset returns the sequencer and divider to idle, no result pending

module super_prime_checker_unit
	import spc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  val_t value,
	output logic done,
	output logic is_prime,
	output logic digits_all_prime,
	output logic super_prime
);

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     prime_flag;
	logic     dig_flag;

	spc_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.value            (value),
		.rsp              (div_rsp),
		.req              (div_req),
		.busy             (busy),
		.done             (done),
		.is_prime         (prime_flag),
		.digits_all_prime (dig_flag)
	);

	spc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign is_prime = prime_flag;
	assign digits_all_prime = dig_flag;
	assign super_prime = prime_flag & dig_flag;

endmodule

[hdl/spc_checker.sv]
// spc_checker: port-level checks for super_prime_checker_unit
// depends on spc_pkg; bound to the top level below

module spc_checker
	import spc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic is_prime,
	input logic digits_all_prime,
	input logic super_prime
);

	ap_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done strobe while not busy");

	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done strobe longer than one cycle");

	ap_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted word did not make the unit busy");

	ap_super: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (super_prime == (is_prime && digits_all_prime)))
		else $error("super_prime flag mismatch");

endmodule

bind super_prime_checker_unit spc_checker u_spc_checker (.*);

[tb/sv/super_prime_checker_unit_tb.sv]
// super_prime_checker_unit_tb: self-checking bench for the super prime checker
// predicts the three flags of each accepted word and checks every done strobe against them
// depends on spc_pkg and super_prime_checker_unit

`timescale 1ns / 1ps

module super_prime_checker_unit_tb;
	import spc_pkg::*;

	localparam int RESET_CYCLES = 4;
	localparam int RANDOM_WORDS = 75;
	localparam int PAIR_BUDGET = 300;
	localparam int TAIL_CYCLES = 80;
	localparam int IDLE_LIMIT = 2000000;

	typedef struct packed {
		logic is_prime;
		logic digits_all_prime;
		logic super_prime;
	} prime_flags_t;

	class prime_flag_board;
		prime_flags_t flags_q[$];
		int errors;

		static function prime_flags_t classify(input val_t v, output int pairs);
			longint unsigned n;
			longint unsigned d;
			longint unsigned rest;
			longint unsigned dig;
			prime_flags_t f;
			n = v;
			pairs = 0;
			f.is_prime = 1'b1;
			if (n <= 1) begin
				f.is_prime = 1'b0;
			end else if (n <= 3) begin
				f.is_prime = 1'b1;
			end else if (n % 2 == 0 || n % 3 == 0) begin
				f.is_prime = 1'b0;
			end else begin
				d = 5;
				while (f.is_prime && d <= n / d) begin
					pairs++;
					if (n % d == 0 || n % (d + 2) == 0)
						f.is_prime = 1'b0;
					d += 6;
				end
			end
			f.digits_all_prime = 1'b1;
			rest = n;
			while (rest > 0) begin
				dig = rest % 10;
				if (dig != 2 && dig != 3 && dig != 5 && dig != 7)
					f.digits_all_prime = 1'b0;
				rest = rest / 10;
			end
			f.super_prime = f.is_prime && f.digits_all_prime;
			return f;
		endfunction

		function void note_word(input val_t v);
			int pairs;
			flags_q.push_back(classify(v, pairs));
		endfunction

		function void check_result(input prime_flags_t got);
			prime_flags_t want;
			if (flags_q.size() == 0) begin
				$error("result with no word pending");
				errors++;
			end else begin
				want = flags_q.pop_front();
				if (got.is_prime !== want.is_prime) begin
					$error("is_prime: expected %0b, got %0b", want.is_prime, got.is_prime);
					errors++;
				end
				if (got.digits_all_prime !== want.digits_all_prime) begin
					$error("digits_all_prime: expected %0b, got %0b",
						want.digits_all_prime, got.digits_all_prime);
					errors++;
				end
				if (got.super_prime !== want.super_prime) begin
					$error("super_prime: expected %0b, got %0b",
						want.super_prime, got.super_prime);
					errors++;
				end
			end
		endfunction

		function int pending();
			return flags_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	val_t value;
	logic done;
	logic is_prime;
	logic digits_all_prime;
	logic super_prime;

	prime_flag_board board;
	int idle_cycles;

	super_prime_checker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.done(done),
		.is_prime(is_prime),
		.digits_all_prime(digits_all_prime),
		.super_prime(super_prime)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(prime_flags_t'({is_prime, digits_all_prime, super_prime}));
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send_word(input val_t v);
		start <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (busy);
		board.note_word(v);
	endtask

	function automatic val_t prime_digit_number(input int digits);
		longint unsigned acc;
		acc = 0;
		repeat (digits) begin
			case ($urandom_range(0, 3))
				0: acc = acc * 10 + DIG_TWO;
				1: acc = acc * 10 + DIG_THREE;
				2: acc = acc * 10 + DIG_FIVE;
				default: acc = acc * 10 + DIG_SEVEN;
			endcase
		end
		return val_t'(acc);
	endfunction

	// keep the trial division short so the random part stays cheap
	function automatic val_t pick_word();
		int kind;
		int pairs;
		val_t v;
		prime_flags_t f;
		kind = $urandom_range(0, 99);
		do begin
			if (kind < 40)
				v = val_t'($urandom_range(0, 9999));
			else if (kind < 60)
				v = prime_digit_number($urandom_range(1, 9));
			else if (kind < 85)
				v = val_t'($urandom);
			else
				v = val_t'($urandom_range(0, (1 << 20) - 1));
			f = prime_flag_board::classify(v, pairs);
		end while (pairs > PAIR_BUDGET);
		return v;
	endfunction

	val_t directed_words[$] = '{
		0, 1, 2, 3, 4, 5, 7, 9, 23, 25, 29, 35, 37, 49, 73, 121, 143, 373, 2357,
		1018081, 7777777, 1073741824, 2147483645, 2147483646, 2147483647
	};

	initial begin
		int burst_left;
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_words[i])
			send_word(directed_words[i]);

		burst_left = $urandom_range(1, 8);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			send_word(pick_word());
			burst_left--;
			if (burst_left == 0 && i != RANDOM_WORDS - 1) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 8);
			end
		end
		start <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
